/* rtl/bmpd_pkg.sv */
// ============================================================================
// bmpd_pkg: shared types and constants for the button press detector
// Window size, configuration register indexes, event codes and the structs
// passed between the detector's modules.
// ============================================================================
package bmpd_pkg;

  // Majority window length in samples.
  localparam int WINDOW_BITS = 32;
  localparam int WIN_HALF    = WINDOW_BITS / 2;
  localparam int WIN_CNT_W   = $clog2(WINDOW_BITS + 1);

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int COUNT_W = 8;

  // Bus widths: input item is 40 bits, result item is 16 bits.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ACTIVE_LEVEL = 2'd0;
  localparam cfg_idx_t CFG_LONG_PRESS   = 2'd1;
  localparam cfg_idx_t CFG_MULTI_GAP    = 2'd2;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_LONG  = 2'd1,
    EVT_MULTI = 2'd2
  } event_t;

  typedef struct packed {
    logic              active_level;
    logic [CFG_W-1:0]  long_press_ms;
    logic [CFG_W-1:0]  multi_press_gap_ms;
  } cfg_t;

  // Packed with the first field in the highest bits.
  typedef struct packed {
    logic               armed;
    logic               debounced;
    logic [COUNT_W-1:0] press_count;
    event_t             event_res;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

/* rtl/bmpd_cfg.sv */
// ============================================================================
// bmpd_cfg: configuration register file
// Holds the active level and the two time thresholds; writes to an index
// outside the register list are taken and ignored.
// ============================================================================
module bmpd_cfg
  import bmpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  input  cfg_idx_t         wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output logic             wr_ready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        CFG_ACTIVE_LEVEL: cfg_nxt.active_level       = wr_data[0];
        CFG_LONG_PRESS:   cfg_nxt.long_press_ms      = wr_data;
        CFG_MULTI_GAP:    cfg_nxt.multi_press_gap_ms = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level       <= 1'b0;
      cfg_r.long_press_ms      <= 16'd3000;
      cfg_r.multi_press_gap_ms <= 16'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/bmpd_core.sv */
// ============================================================================
// bmpd_core: debounce and press classification
// Updates the detector state for one accepted sample and forms its result.
// The window population is tracked incrementally instead of recounted.
// ============================================================================
module bmpd_core
  import bmpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              raw_level,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output result_t           result
);

  logic [WINDOW_BITS-1:0] window_r,  window_nxt;
  logic [WIN_CNT_W-1:0]   win_cnt_r, win_cnt_nxt;
  logic                   armed_r,   armed_nxt;
  logic                   last_lvl_r, last_lvl_nxt;
  logic [TIME_W-1:0]      change_r,  change_nxt;
  logic [COUNT_W-1:0]     presses_r, presses_nxt;
  logic                   prev_raw_r;

  logic                   act;
  logic [WINDOW_BITS-1:0] win_shift;
  logic [WIN_CNT_W-1:0]   cnt_shift;
  logic                   deb;
  logic [TIME_W-1:0]      elapsed;
  event_t                 evt;

  localparam logic [WINDOW_BITS-1:0] WIN_PRESET =
    {{(WINDOW_BITS - WIN_HALF){1'b0}}, {WIN_HALF{1'b1}}};
  localparam logic [WIN_CNT_W-1:0] CNT_PRESET = WIN_CNT_W'(WIN_HALF);
  localparam logic [COUNT_W-1:0]   COUNT_MAX  = {COUNT_W{1'b1}};

  always_comb begin
    act       = (raw_level == cfg.active_level);
    win_shift = {window_r[WINDOW_BITS-2:0], act};
    // New population: add the incoming bit, drop the bit leaving the top.
    cnt_shift = win_cnt_r + WIN_CNT_W'(act) - WIN_CNT_W'(window_r[WINDOW_BITS-1]);
    elapsed   = now_ms - change_r;

    window_nxt   = window_r;
    win_cnt_nxt  = win_cnt_r;
    armed_nxt    = armed_r;
    last_lvl_nxt = last_lvl_r;
    change_nxt   = change_r;
    presses_nxt  = presses_r;
    deb          = 1'b0;
    evt          = EVT_NONE;

    if (!armed_r) begin
      if (act && (prev_raw_r != cfg.active_level)) begin
        armed_nxt    = 1'b1;
        window_nxt   = WIN_PRESET;
        win_cnt_nxt  = CNT_PRESET;
        last_lvl_nxt = 1'b1;
        change_nxt   = now_ms;
        presses_nxt  = '0;
        deb          = 1'b1;
      end
    end else begin
      window_nxt  = win_shift;
      win_cnt_nxt = cnt_shift;
      deb         = (cnt_shift > CNT_PRESET);
      if (!deb && !last_lvl_r) begin
        if (elapsed >= TIME_W'(cfg.multi_press_gap_ms)) begin
          if (presses_r > COUNT_W'(1)) begin
            evt = EVT_MULTI;
          end
          armed_nxt = 1'b0;
        end
      end else if (deb && last_lvl_r) begin
        if ((elapsed >= TIME_W'(cfg.long_press_ms)) && (presses_r == '0)) begin
          evt       = EVT_LONG;
          armed_nxt = 1'b0;
        end
      end else begin
        if (!deb && (presses_r != COUNT_MAX)) begin
          presses_nxt = presses_r + COUNT_W'(1);
        end
        last_lvl_nxt = deb;
        change_nxt   = now_ms;
      end
    end

    result.event_res   = evt;
    result.press_count = presses_nxt;
    result.debounced   = deb;
    result.armed       = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      window_r   <= '0;
      win_cnt_r  <= '0;
      last_lvl_r <= 1'b0;
      change_r   <= '0;
      presses_r  <= '0;
      prev_raw_r <= 1'b0;
    end else if (accept) begin
      armed_r    <= armed_nxt;
      window_r   <= window_nxt;
      win_cnt_r  <= win_cnt_nxt;
      last_lvl_r <= last_lvl_nxt;
      change_r   <= change_nxt;
      presses_r  <= presses_nxt;
      prev_raw_r <= raw_level;
    end
  end

endmodule

/* rtl/bmpd_obuf.sv */
// ============================================================================
// bmpd_obuf: result register with skid entry
// Holds results for the output channel; the skid entry absorbs one result
// while the output is stalled so that input ready never waits on output ready.
// ============================================================================
module bmpd_obuf
  import bmpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r,  out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r,   out_data_nxt;
  result_t skid_data_r,  skid_data_nxt;
  logic    take;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    take           = out_valid_r && out_ready;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;

    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

/* rtl/button_long_and_multi_press_detector_unit.sv */
// ============================================================================
// button_long_and_multi_press_detector_unit: debounced long/multi press
// Debounces raw button samples with a majority window and reports long
// presses and multi-press runs, one result per sample.
// ============================================================================
//
//  Channel  Direction  Handshake                 Contents
//  in_      slave      in_tvalid / in_tready     raw_level, now_ms
//  out_     master     out_tvalid / out_tready   event_res, press_count,
//                                                debounced, armed
//  cfg_     slave      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each accepted sample is processed in the cycle it is accepted: the state
// update and the result are formed by one level of logic and the result is
// registered. A new sample can be taken every cycle while in_tready is high;
// the rate is set by the single state update loop. Reset is synchronous and
// active low; it restores the register defaults and leaves the block idle.
// A stalled output holds one result in the output register and one more in
// a skid entry; only when both are full is in_tready dropped.
// The configuration port is always ready.
//
module button_long_and_multi_press_detector_unit
  import bmpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input samples.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] raw_level, [32:1] now_ms, [39:33] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Results.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] event_res, [9:2] press_count, [10] debounced, [11] armed,
  // [15:12] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    in_accept;

  // A sample transaction completes when both sides of the handshake agree.
  assign in_accept = in_tvalid && in_tready;

  bmpd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .wr_ready (cfg_ready),
    .cfg      (cfg)
  );

  // The core commits its state only on an accepted transaction.
  bmpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .raw_level (in_tdata[0]),
    .now_ms    (in_tdata[TIME_W:1]),
    .cfg       (cfg),
    .result    (core_res)
  );

  bmpd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (core_res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res};

`ifndef ASSERT_OFF
  // Any reported event ends the run, so the block must be disarmed with it.
  a_event_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (core_res.event_res != EVT_NONE) |-> !core_res.armed)
    else $error("event reported while block stays armed");

  // A long press is only reported before any release was counted.
  a_long_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (core_res.event_res == EVT_LONG) |-> (core_res.press_count == '0))
    else $error("long press reported with non-zero press count");

  // The detector never produces an undefined event code.
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.event_res == EVT_NONE || out_res.event_res == EVT_LONG ||
                    out_res.event_res == EVT_MULTI))
    else $error("undefined event code on output");

  // Input back-pressure only arises while a result is waiting on the output.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !$past(out_tready))
    else $error("input stalled without a blocked output");
`endif

endmodule
